@@ sv/content_defined_chunker_unit_macros.svh @@
// Assertion helpers used by the chunker core (cdc_core).
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef CONTENT_DEFINED_CHUNKER_UNIT_MACROS_SVH
`define CONTENT_DEFINED_CHUNKER_UNIT_MACROS_SVH

// Same-cycle implication
`define CDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cdc_pkg.sv @@
package cdc_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LEFT_W  = 21;
    localparam int SIZE_W  = 16;
    localparam int HASH_W  = 32;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 32;

    // Gear table and weak-hash sampling
    localparam int TABLE_ENTRIES  = 256;
    localparam int SAMPLE_SPACING = 16;
    localparam int SPC_W = (SAMPLE_SPACING > 1) ? $clog2(SAMPLE_SPACING) : 1;
    localparam logic [SPC_W-1:0] SPC_LAST = SPC_W'(SAMPLE_SPACING - 1);

    // Result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Register reset values
    localparam logic [SIZE_W-1:0] MIN_SIZE_RST    = 16'd2028;
    localparam logic [SIZE_W-1:0] NORMAL_SIZE_RST = 16'd8192;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RST    = 16'd32768;
    localparam logic [HASH_W-1:0] SMALL_MASK_RST  = 32'hf9070353;
    localparam logic [HASH_W-1:0] LARGE_MASK_RST  = 32'hd9000353;

    // Configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_MIN_SIZE    = 3'd0,
        REG_NORMAL_SIZE = 3'd1,
        REG_MAX_SIZE    = 3'd2,
        REG_SMALL_MASK  = 3'd3,
        REG_LARGE_MASK  = 3'd4
    } cfg_reg_t;

    // Chunk end codes
    typedef enum logic [KIND_W-1:0] {
        END_SMALL = 2'd0,
        END_LARGE = 2'd1,
        END_LIMIT = 2'd2
    } end_kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0] min_size;
        logic [SIZE_W-1:0] normal_size;
        logic [SIZE_W-1:0] max_size;
        logic [HASH_W-1:0] small_mask;
        logic [HASH_W-1:0] large_mask;
    } cfg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] chunk_length;
        logic [HASH_W-1:0] weak_hash;
        logic [KIND_W-1:0] end_kind;
        logic              last_of_run;
    } res_t;

    // Up to two results per byte, pushed into the result queue together
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

    // MD5 round constants and shifts
    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Gear word for byte value v: MD5 word A over 64 copies of v.
    // Evaluated at elaboration only.
    function automatic logic [31:0] gear_word(input logic [7:0] v);
        logic [31:0] st [4];
        logic [31:0] m [16];
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        int          g;
        int          r;
        int          s;
        st[0] = 32'h67452301;
        st[1] = 32'hefcdab89;
        st[2] = 32'h98badcfe;
        st[3] = 32'h10325476;
        for (int blk = 0; blk < 2; blk++)
        begin
            for (int j = 0; j < 16; j++)
            begin
                m[j] = (blk == 0) ? {4{v}} : 32'h0;
            end
            if (blk == 1)
            begin
                m[0]  = 32'h80;
                m[14] = 32'd512;
            end
            a = st[0];
            b = st[1];
            c = st[2];
            d = st[3];
            for (int i = 0; i < 64; i++)
            begin
                r = i >> 4;
                if (r == 0)
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                else if (r == 1)
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) & 15;
                end
                else if (r == 2)
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) & 15;
                end
                else
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) & 15;
                end
                f = f + a + MD5_K[i] + m[g];
                s = MD5_S[(r << 2) | (i & 3)];
                a = d;
                d = c;
                c = b;
                b = b + ((f << s) | (f >> (32 - s)));
            end
            st[0] = st[0] + a;
            st[1] = st[1] + b;
            st[2] = st[2] + c;
            st[3] = st[3] + d;
        end
        return st[0];
    endfunction

endpackage

@@ sv/cdc_byte_if.sv @@
interface cdc_byte_if;
    logic                        valid;
    logic                        ready;
    logic [cdc_pkg::BYTE_W-1:0] data_byte;
    logic [cdc_pkg::LEFT_W-1:0] bytes_left;

    modport source (output valid, output data_byte, output bytes_left, input ready);
    modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

@@ sv/cdc_chunk_if.sv @@
interface cdc_chunk_if;
    logic                        valid;
    logic                        ready;
    logic [cdc_pkg::SIZE_W-1:0] chunk_length;
    logic [cdc_pkg::HASH_W-1:0] weak_hash;
    logic [cdc_pkg::KIND_W-1:0] end_kind;
    logic                        last_of_run;

    modport source (output valid, output chunk_length, output weak_hash, output end_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input chunk_length, input weak_hash, input end_kind,
                    input last_of_run, output ready);
endinterface

@@ sv/cdc_cfg_if.sv @@
interface cdc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [cdc_pkg::INDEX_W-1:0] index;
    logic [cdc_pkg::DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/cdc_gear_rom.sv @@
module cdc_gear_rom (
    input  logic [cdc_pkg::BYTE_W-1:0] addr,
    output logic [cdc_pkg::HASH_W-1:0] word
);

    logic [cdc_pkg::HASH_W-1:0] rom [cdc_pkg::TABLE_ENTRIES];

    // Table contents fixed at elaboration
    for (genvar v = 0; v < cdc_pkg::TABLE_ENTRIES; v++)
    begin : g_word
        localparam logic [cdc_pkg::HASH_W-1:0] WORD = cdc_pkg::gear_word(8'(v));
        assign rom[v] = WORD;
    end

    assign word = rom[addr];

endmodule

@@ sv/cdc_core.sv @@
`include "content_defined_chunker_unit_macros.svh"

module cdc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    cdc_byte_if.sink             byte_in,
    input  cdc_pkg::cfg_t        cfg,
    input  logic                 room,
    output cdc_pkg::push_t       push
);

    // Input register
    logic                         in_valid_reg, in_valid_next;
    logic [cdc_pkg::BYTE_W-1:0]  byte_reg;
    logic [cdc_pkg::LEFT_W-1:0]  left_reg;

    // Chunk state
    logic [cdc_pkg::HASH_W-1:0]  print_reg, print_next;
    logic [cdc_pkg::HASH_W-1:0]  sum_reg, sum_next;
    logic [cdc_pkg::SIZE_W-1:0]  pos_reg, pos_next;
    logic [cdc_pkg::SPC_W-1:0]   spc_reg, spc_next;
    logic [cdc_pkg::SIZE_W-1:0]  normal_reg, normal_next;
    logic [cdc_pkg::SIZE_W-1:0]  limit_reg, limit_next;
    logic                         open_reg, open_next;

    logic                         accept;
    logic                         fire;
    logic [cdc_pkg::HASH_W-1:0]  word;

    // Continuing-chunk terms
    logic                         sample_o;
    logic [cdc_pkg::SPC_W-1:0]   spc_o;
    logic [cdc_pkg::HASH_W-1:0]  print_o;
    logic                         small_o;
    logic [cdc_pkg::HASH_W-1:0]  sum_o;
    logic                         cut_o;
    logic                         mask_cut;
    logic [cdc_pkg::SIZE_W-1:0]  pos_inc;
    logic                         hit_limit;

    // New-chunk terms
    logic                         begin_chunk;
    logic [cdc_pkg::SIZE_W-1:0]  lim_clip;
    logic [cdc_pkg::SIZE_W-1:0]  lim_new;
    logic [cdc_pkg::SIZE_W-1:0]  normal_new;
    logic                         sample_b;
    logic [cdc_pkg::HASH_W-1:0]  sum_b;
    logic                         new_lim1;

    cdc_pkg::res_t                r_cut, r_lim_old, r_lim_new;

    cdc_gear_rom u_rom (
        .addr (byte_reg),
        .word (word)
    );

    // Handshake: the input register refills whenever its word moves on
    assign fire            = in_valid_reg && room;
    assign byte_in.ready   = !in_valid_reg || room;
    assign accept          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Byte absorbed into the open chunk
    always_comb
    begin
        sample_o  = (spc_reg == cdc_pkg::SPC_LAST);
        spc_o     = sample_o ? '0 : spc_reg + 1'b1;
        print_o   = {print_reg[cdc_pkg::HASH_W-2:0], 1'b0} + word;
        small_o   = pos_reg < normal_reg;
        if (small_o)
        begin
            sum_o = sample_o ? sum_reg + word : sum_reg;
            cut_o = ((print_o & cfg.small_mask) == '0) && (pos_reg >= cfg.min_size);
        end
        else
        begin
            sum_o = (sum_reg + word) ^ (sample_o ? word : '0);
            cut_o = (print_o & cfg.large_mask) == '0;
        end
        mask_cut  = open_reg && cut_o && (pos_reg != '0);
        pos_inc   = pos_reg + 1'b1;
        hit_limit = pos_inc >= limit_reg;
    end

    // Byte that opens a new chunk
    always_comb
    begin
        begin_chunk = !open_reg || mask_cut;
        lim_clip    = (left_reg > cdc_pkg::LEFT_W'(cfg.max_size))
                      ? cfg.max_size : left_reg[cdc_pkg::SIZE_W-1:0];
        lim_new     = (lim_clip == '0) ? cdc_pkg::SIZE_W'(1) : lim_clip;
        normal_new  = (cfg.normal_size < lim_new) ? cfg.normal_size : lim_new;
        sample_b    = (cdc_pkg::SPC_LAST == '0);
        if (normal_new != '0)
        begin
            sum_b = sample_b ? word : '0;
        end
        else
        begin
            sum_b = word ^ (sample_b ? word : '0);
        end
        new_lim1    = begin_chunk && (lim_new == cdc_pkg::SIZE_W'(1));
    end

    // Next chunk state
    always_comb
    begin
        if (begin_chunk)
        begin
            print_next  = word;
            sum_next    = sum_b;
            spc_next    = sample_b ? '0 : cdc_pkg::SPC_W'(1);
            pos_next    = cdc_pkg::SIZE_W'(1);
            limit_next  = lim_new;
            normal_next = normal_new;
            open_next   = !new_lim1;
        end
        else
        begin
            print_next  = print_o;
            sum_next    = sum_o;
            spc_next    = spc_o;
            pos_next    = pos_inc;
            limit_next  = limit_reg;
            normal_next = normal_reg;
            open_next   = !hit_limit;
        end
    end

    // Results caused by this byte
    always_comb
    begin
        r_cut.chunk_length     = pos_reg;
        r_cut.weak_hash        = sum_o;
        r_cut.end_kind         = small_o ? cdc_pkg::END_SMALL : cdc_pkg::END_LARGE;
        r_cut.last_of_run      = !new_lim1;
        r_lim_old.chunk_length = limit_reg;
        r_lim_old.weak_hash    = sum_o;
        r_lim_old.end_kind     = cdc_pkg::END_LIMIT;
        r_lim_old.last_of_run  = 1'b1;
        r_lim_new.chunk_length = cdc_pkg::SIZE_W'(1);
        r_lim_new.weak_hash    = sum_b;
        r_lim_new.end_kind     = cdc_pkg::END_LIMIT;
        r_lim_new.last_of_run  = 1'b1;

        push.r0  = r_lim_new;
        push.r1  = r_lim_new;
        push.cnt = 2'd0;
        if (fire)
        begin
            if (mask_cut)
            begin
                push.r0  = r_cut;
                push.cnt = new_lim1 ? 2'd2 : 2'd1;
            end
            else if (open_reg)
            begin
                push.r0  = r_lim_old;
                push.cnt = hit_limit ? 2'd1 : 2'd0;
            end
            else
            begin
                push.cnt = new_lim1 ? 2'd1 : 2'd0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            print_reg    <= '0;
            sum_reg      <= '0;
            pos_reg      <= '0;
            spc_reg      <= '0;
            normal_reg   <= '0;
            limit_reg    <= '0;
            open_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                print_reg  <= print_next;
                sum_reg    <= sum_next;
                pos_reg    <= pos_next;
                spc_reg    <= spc_next;
                normal_reg <= normal_next;
                limit_reg  <= limit_next;
                open_reg   <= open_next;
            end
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_in.data_byte;
            left_reg <= byte_in.bytes_left;
        end
    end

    `CDC_ASSERT_IMP(a_pos_in_range, open_reg,
        (pos_reg != '0) && (pos_reg < limit_reg), "open chunk position out of range")
    `CDC_ASSERT_IMP(a_normal_le_limit, open_reg,
        normal_reg <= limit_reg, "normal point beyond limit")
    `CDC_ASSERT_IMP(a_pair_shape, fire && (push.cnt == 2'd2),
        (push.r0.end_kind != cdc_pkg::END_LIMIT) && (push.r1.chunk_length == 16'd1),
        "two results must be a mask cut then a one-byte limit chunk")
    `CDC_ASSERT_NEXT(a_hold_state, !fire,
        $stable(pos_reg) && $stable(open_reg), "chunk state moved without a byte")

endmodule

@@ sv/cdc_res_fifo.sv @@
module cdc_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  cdc_pkg::push_t    push,
    output logic              room,
    cdc_chunk_if.source       chunk_out
);

    cdc_pkg::res_t                  mem [cdc_pkg::RES_DEPTH];
    logic [cdc_pkg::RES_PTR_W-1:0] wr_reg, wr_next;
    logic [cdc_pkg::RES_PTR_W-1:0] rd_reg, rd_next;
    logic [cdc_pkg::RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           pop;
    logic [cdc_pkg::RES_PTR_W-1:0] wr_second;

    // Room for a full pair of results
    assign room      = cnt_reg <= cdc_pkg::RES_CNT_W'(cdc_pkg::RES_DEPTH - 2);
    assign pop       = chunk_out.valid && chunk_out.ready;
    assign wr_second = wr_reg + 1'b1;

    always_comb
    begin
        wr_next  = wr_reg + cdc_pkg::RES_PTR_W'(push.cnt);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + cdc_pkg::RES_CNT_W'(push.cnt)
                   - cdc_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_second] <= push.r1;
        end
    end

    // Head of queue drives the output word
    assign chunk_out.valid        = cnt_reg != '0;
    assign chunk_out.chunk_length = mem[rd_reg].chunk_length;
    assign chunk_out.weak_hash    = mem[rd_reg].weak_hash;
    assign chunk_out.end_kind     = mem[rd_reg].end_kind;
    assign chunk_out.last_of_run  = mem[rd_reg].last_of_run;

endmodule

@@ sv/content_defined_chunker_unit.sv @@
// Gear-hash content-defined chunker. Takes one data byte per clock on byte_in
// and reports each finished chunk on chunk_out as a word holding its length,
// sampled weak hash and end kind (small-mask cut, large-mask cut, limit).
// The bytes_left field is used only on a byte that opens a chunk. A byte that
// triggers a mask cut closes the previous chunk and opens the next one; if
// that new chunk's limit is one byte it yields a second word, and last_of_run
// marks the final word caused by a byte. Throughput is one byte per clock:
// the gear table lookup, rolling shift-add and mask test sit between the
// input register and a four-word result queue, from which results go out on
// chunk_out. byte_in stalls only while the input register holds a byte and
// the result queue lacks room for two words. The user must write registers
// through cfg only while no byte is in flight; the block does not enforce it.
module content_defined_chunker_unit (
    input  logic         clk,
    input  logic         rst_n,
    cdc_byte_if.sink     byte_in,
    cdc_chunk_if.source  chunk_out,
    cdc_cfg_if.sink      cfg
);

    cdc_pkg::cfg_t   cfg_reg;
    cdc_pkg::push_t  push;
    logic            room;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_size    <= cdc_pkg::MIN_SIZE_RST;
            cfg_reg.normal_size <= cdc_pkg::NORMAL_SIZE_RST;
            cfg_reg.max_size    <= cdc_pkg::MAX_SIZE_RST;
            cfg_reg.small_mask  <= cdc_pkg::SMALL_MASK_RST;
            cfg_reg.large_mask  <= cdc_pkg::LARGE_MASK_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cdc_pkg::cfg_reg_t'(cfg.index))
                cdc_pkg::REG_MIN_SIZE:
                    cfg_reg.min_size    <= cfg.data[cdc_pkg::SIZE_W-1:0];
                cdc_pkg::REG_NORMAL_SIZE:
                    cfg_reg.normal_size <= cfg.data[cdc_pkg::SIZE_W-1:0];
                cdc_pkg::REG_MAX_SIZE:
                    cfg_reg.max_size    <= cfg.data[cdc_pkg::SIZE_W-1:0];
                cdc_pkg::REG_SMALL_MASK:
                    cfg_reg.small_mask  <= cfg.data;
                cdc_pkg::REG_LARGE_MASK:
                    cfg_reg.large_mask  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    cdc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .cfg     (cfg_reg),
        .room    (room),
        .push    (push)
    );

    cdc_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .chunk_out (chunk_out)
    );

endmodule

@@ verif/tb_content_defined_chunker_unit.sv @@
`timescale 1ns / 1ps

module tb_content_defined_chunker_unit;
    import cdc_pkg::*;

    // Index outside the register map; writes to it must change nothing
    localparam logic [INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    typedef struct {
        bit [BYTE_W-1:0] data;
        bit [LEFT_W-1:0] left;
    } byte_item_t;

    logic clk;
    logic rst_n;

    cdc_byte_if  byte_if ();
    cdc_chunk_if chunk_if ();
    cdc_cfg_if   cfg_if ();

    content_defined_chunker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_if),
        .chunk_out (chunk_if),
        .cfg       (cfg_if)
    );

    // Predictor state: gear ROM, rolling print, chunk bookkeeping
    bit [31:0]       sine_k [64];
    bit [HASH_W-1:0] gear_rom [TABLE_ENTRIES];
    bit [HASH_W-1:0] fp;
    bit [HASH_W-1:0] wsum;
    bit [SIZE_W-1:0] pos;
    bit [SIZE_W-1:0] norm_end;
    bit [SIZE_W-1:0] lim_end;
    bit [SPC_W-1:0]  spc;
    bit              in_chunk;

    // Predictor copy of the registers
    bit [SIZE_W-1:0] r_min;
    bit [SIZE_W-1:0] r_norm;
    bit [SIZE_W-1:0] r_max;
    bit [HASH_W-1:0] r_smask;
    bit [HASH_W-1:0] r_lmask;

    byte_item_t pending_bytes [$];
    res_t       exp_chunks [$];

    bit byte_fired;
    bit calm;
    bit stall_req;
    bit hold_done;
    int src_gap;
    int snk_gap;
    int hold_left;
    int err_count;

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // MD5 additive constants from the sine definition
    function automatic bit [31:0] sine_word(input int i);
        real x;
        x = $sin(i + 1.0);
        if (x < 0.0)
            x = -x;
        return 32'(longint'($floor(x * 4294967296.0)));
    endfunction

    // Word A of MD5 over 64 copies of v (two compression passes)
    function automatic bit [31:0] md5_gear(input bit [7:0] v);
        bit [31:0] h [4];
        bit [31:0] blk [16];
        bit [31:0] a;
        bit [31:0] b;
        bit [31:0] c;
        bit [31:0] d;
        bit [31:0] f;
        bit [31:0] t;
        int        g;
        int        sh;
        h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        for (int p = 0; p < 2; p++)
        begin
            for (int j = 0; j < 16; j++)
                blk[j] = (p == 0) ? {4{v}} : 32'h0;
            if (p == 1)
            begin
                blk[0]  = 32'h80;
                blk[14] = 32'd512;
            end
            a = h[0];
            b = h[1];
            c = h[2];
            d = h[3];
            for (int i = 0; i < 64; i++)
            begin
                case (i / 16)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        g = (5 * i + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                t  = a + f + sine_k[i] + blk[g];
                sh = ROT_AMT[(i / 16) * 4 + (i % 4)];
                a  = d;
                d  = c;
                c  = b;
                b  = b + ((t << sh) | (t >> (32 - sh)));
            end
            h[0] = h[0] + a;
            h[1] = h[1] + b;
            h[2] = h[2] + c;
            h[3] = h[3] + d;
        end
        return h[0];
    endfunction

    // Shift one byte into the print and weak hash; returns the mask decision
    function automatic bit gear_absorb(input bit [7:0] b);
        bit [HASH_W-1:0] w;
        bit              tick;
        w    = gear_rom[b];
        tick = (spc == SPC_LAST);
        spc  = tick ? '0 : spc + 1'b1;
        fp   = (fp << 1) + w;
        if (pos < norm_end)
        begin
            if (tick)
                wsum = wsum + w;
            return ((fp & r_smask) == '0) && (pos >= r_min);
        end
        wsum = wsum + w;
        if (tick)
            wsum = wsum ^ w;
        return (fp & r_lmask) == '0;
    endfunction

    function automatic res_t chunk_word(input bit [SIZE_W-1:0] len, input end_kind_t kind);
        res_t r;
        r.chunk_length = len;
        r.weak_hash    = wsum;
        r.end_kind     = kind;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // Expected chunk words for one accepted byte
    task automatic predict_chunks(input bit [7:0] b, input bit [LEFT_W-1:0] left);
        res_t            got [2];
        int              n;
        bit              opening;
        bit [SIZE_W-1:0] p;
        bit              narrow;
        bit              cut;
        bit [LEFT_W-1:0] lim;
        n       = 0;
        opening = 1'b1;
        if (in_chunk)
        begin
            p      = pos;
            narrow = p < norm_end;
            cut    = gear_absorb(b);
            if (cut && p != 0)
            begin
                got[n]   = chunk_word(p, narrow ? END_SMALL : END_LARGE);
                n++;
                in_chunk = 1'b0;
            end
            else
            begin
                opening = 1'b0;
                pos     = p + 1'b1;
                if (pos >= lim_end)
                begin
                    got[n]   = chunk_word(lim_end, END_LIMIT);
                    n++;
                    in_chunk = 1'b0;
                end
            end
        end
        if (opening)
        begin
            lim = left;
            if (lim > LEFT_W'(r_max))
                lim = LEFT_W'(r_max);
            if (lim == 0)
                lim = LEFT_W'(1);
            lim_end  = lim[SIZE_W-1:0];
            norm_end = (r_norm < lim_end) ? r_norm : lim_end;
            fp       = '0;
            wsum     = '0;
            spc      = '0;
            pos      = '0;
            in_chunk = 1'b1;
            void'(gear_absorb(b));
            pos = SIZE_W'(1);
            if (pos >= lim_end)
            begin
                got[n]   = chunk_word(lim_end, END_LIMIT);
                n++;
                in_chunk = 1'b0;
            end
        end
        if (n > 0)
            got[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            exp_chunks.push_back(got[i]);
    endtask

    // Byte driver: holds a word until taken, idles in random bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_fired)
                void'(pending_bytes.pop_front());
            if (!(byte_if.valid && !byte_fired))
            begin
                if (src_gap == 0 && !calm && $urandom_range(0, 15) == 0)
                    src_gap = $urandom_range(1, 11);
                if (src_gap > 0)
                begin
                    src_gap--;
                    byte_if.valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    byte_if.valid      <= 1'b1;
                    byte_if.data_byte  <= pending_bytes[0].data;
                    byte_if.bytes_left <= pending_bytes[0].left;
                end
                else
                    byte_if.valid <= 1'b0;
            end
        end
    end

    // Chunk receiver: random stall bursts plus one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chunk_if.ready <= 1'b0;
            end
            else
            begin
                if (snk_gap == 0 && !calm && $urandom_range(0, 15) == 0)
                    snk_gap = $urandom_range(1, 11);
                if (snk_gap > 0)
                begin
                    snk_gap--;
                    chunk_if.ready <= 1'b0;
                end
                else
                    chunk_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on each byte taken, check each chunk word against the oldest
    always @(posedge clk)
    begin
        res_t want;
        byte_fired = rst_n && byte_if.valid && byte_if.ready;
        if (byte_fired)
            predict_chunks(byte_if.data_byte, byte_if.bytes_left);
        if (rst_n && chunk_if.valid && chunk_if.ready)
        begin
            if (exp_chunks.size() == 0)
            begin
                $error("chunk word with none expected: length %0d hash %h kind %0d last %0d",
                       chunk_if.chunk_length, chunk_if.weak_hash, chunk_if.end_kind,
                       chunk_if.last_of_run);
                err_count++;
            end
            else
            begin
                want = exp_chunks.pop_front();
                if (chunk_if.chunk_length !== want.chunk_length)
                begin
                    $error("chunk_length: expected %0d, actual %0d",
                           want.chunk_length, chunk_if.chunk_length);
                    err_count++;
                end
                if (chunk_if.weak_hash !== want.weak_hash)
                begin
                    $error("weak_hash: expected %h, actual %h",
                           want.weak_hash, chunk_if.weak_hash);
                    err_count++;
                end
                if (chunk_if.end_kind !== want.end_kind)
                begin
                    $error("end_kind: expected %0d, actual %0d",
                           want.end_kind, chunk_if.end_kind);
                    err_count++;
                end
                if (chunk_if.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, chunk_if.last_of_run);
                    err_count++;
                end
            end
        end
    end

    // One register write through the cfg channel
    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            REG_MIN_SIZE:    r_min   = val[SIZE_W-1:0];
            REG_NORMAL_SIZE: r_norm  = val[SIZE_W-1:0];
            REG_MAX_SIZE:    r_max   = val[SIZE_W-1:0];
            REG_SMALL_MASK:  r_smask = val;
            REG_LARGE_MASK:  r_lmask = val;
            default:         ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_settings(input bit [15:0] mn, input bit [15:0] nm, input bit [15:0] mx,
                                 input bit [31:0] sm, input bit [31:0] lg);
        write_reg(REG_MIN_SIZE, 32'(mn));
        write_reg(REG_NORMAL_SIZE, 32'(nm));
        write_reg(REG_MAX_SIZE, 32'(mx));
        write_reg(REG_SMALL_MASK, sm);
        write_reg(REG_LARGE_MASK, lg);
    endtask

    task automatic push_byte(input bit [7:0] d, input bit [LEFT_W-1:0] left);
        byte_item_t it;
        it.data = d;
        it.left = left;
        pending_bytes.push_back(it);
    endtask

    // A file of len bytes with bytes_left counting down; stops early after count bytes
    task automatic push_file(input int len, input int count);
        for (int i = 0; i < count; i++)
            push_byte(8'($urandom), LEFT_W'(len - i));
    endtask

    // Mostly whole files with random content, some truncated files and noise
    task automatic random_phase(input int n_items);
        int done;
        int len;
        int pick;
        int k;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 300)
                                                 : $urandom_range(1, 60);
                if (len > n_items - done)
                    len = n_items - done;
                push_file(len, len);
                done += len;
            end
            else if (pick < 17)
            begin
                len = $urandom_range(2, 60);
                k   = $urandom_range(1, len - 1);
                if (k > n_items - done)
                    k = n_items - done;
                push_file(len, k);
                done += k;
            end
            else if (pick < 19)
            begin
                push_byte(8'($urandom), LEFT_W'($urandom));
                done++;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       push_byte(8'($urandom), '0);
                    1:       push_byte(8'($urandom), LEFT_W'(1));
                    2:       push_byte(8'($urandom), '1);
                    default: push_byte(8'($urandom), LEFT_W'(1048576));
                endcase
                done++;
            end
        end
    endtask

    task automatic wait_empty();
        while (pending_bytes.size() != 0 || exp_chunks.size() != 0 || byte_if.valid)
            @(posedge clk);
    endtask

    // Idle point: nothing pending, then room for a byte that yields no word
    task automatic settle();
        wait_empty();
        repeat (8) @(posedge clk);
    endtask

    function automatic bit [31:0] sparse_mask();
        return $urandom & $urandom & $urandom & $urandom;
    endfunction

    // Main sequence
    initial
    begin
        rst_n               = 1'b0;
        byte_if.valid       = 1'b0;
        byte_if.data_byte   = '0;
        byte_if.bytes_left  = '0;
        chunk_if.ready      = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;

        // Gear ROM and register values after reset
        for (int i = 0; i < 64; i++)
            sine_k[i] = sine_word(i);
        for (int v = 0; v < TABLE_ENTRIES; v++)
            gear_rom[v] = md5_gear(8'(v));
        r_min   = MIN_SIZE_RST;
        r_norm  = NORMAL_SIZE_RST;
        r_max   = MAX_SIZE_RST;
        r_smask = SMALL_MASK_RST;
        r_lmask = LARGE_MASK_RST;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: one-byte limit, zero bytes_left, bytes_left above max_size
        push_byte(8'h00, LEFT_W'(1));
        push_byte(8'hff, '0);
        push_byte(8'h80, LEFT_W'(1048576));
        push_byte(8'h7f, LEFT_W'(3));
        settle();
        write_reg(REG_SPARE, 32'hffff_ffff);

        // Zero masks: every byte after the first cuts, the first never does
        load_settings(16'd0, 16'd4, 16'd8, 32'h0, 32'h0);
        push_byte(8'h11, LEFT_W'(1));
        push_byte(8'h22, LEFT_W'(5));
        push_byte(8'h33, LEFT_W'(1));
        push_byte(8'h44, LEFT_W'(20));
        push_byte(8'h55, LEFT_W'(20));
        push_byte(8'h66, LEFT_W'(2));
        push_byte(8'h01, LEFT_W'(9));
        push_byte(8'hfe, '1);
        settle();

        // Zero max_size: every chunk is one byte; full masks
        load_settings(16'd5, 16'hffff, 16'd0, 32'hffff_ffff, 32'hffff_ffff);
        push_byte(8'haa, LEFT_W'(100));
        push_byte(8'h55, '0);
        push_byte(8'hc3, '1);
        settle();

        // Random phases over a range of settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_settings(16'd2, 16'd12, 16'd40, 32'h3, 32'h1);
                1: load_settings(16'd8, 16'd24, 16'd64, 32'hf, 32'h3);
                2: load_settings(16'd0, 16'd1, 16'd30, 32'hffff_ffff, 32'h7);
                3: load_settings(16'hffff, 16'hffff, 16'hffff, 32'h1, 32'h1);
                4: load_settings(16'd3, 16'd50, 16'd25, 32'h8000_0001, 32'h0000_0101);
                5: load_settings(MIN_SIZE_RST, NORMAL_SIZE_RST, MAX_SIZE_RST,
                                 SMALL_MASK_RST, LARGE_MASK_RST);
                default: load_settings(16'($urandom_range(0, 20)), 16'($urandom_range(1, 40)),
                                       16'($urandom_range(1, 80)), sparse_mask(),
                                       sparse_mask());
            endcase
            if (ph == 7)
                calm = 1'b1;
            if (ph == 4)
            begin
                // sender stops until every word is back, then resumes
                random_phase(65);
                wait_empty();
                random_phase(65);
            end
            else
                random_phase(125);
            if (ph == 2)
                stall_req = 1'b1;
            settle();
        end

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_content_defined_chunker_unit: done, clean");
        else
            $display("tb_content_defined_chunker_unit: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_content_defined_chunker_unit: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/cdc_pkg.sv
sv/cdc_byte_if.sv
sv/cdc_chunk_if.sv
sv/cdc_cfg_if.sv
sv/cdc_gear_rom.sv
sv/cdc_core.sv
sv/cdc_res_fifo.sv
sv/content_defined_chunker_unit.sv
verif/tb_content_defined_chunker_unit.sv
